@@ hw/rtl/oal_pkg.sv @@
package oal_pkg;

  // Widths of the request and result fields as they appear on the channels.
  localparam int CMD_BITS          = 3;
  localparam int POS_BITS          = 5;
  localparam int KEY_PORT_BITS     = 64;
  localparam int PAYLOAD_PORT_BITS = 32;
  localparam int STATUS_BITS       = 2;
  localparam int TOTAL_BITS        = 6;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_FULL         = 2'd1,
    STATUS_BAD_POSITION = 2'd2,
    STATUS_NO_KEY       = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain at once.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_UPDATE,
    CELL_SEEK_KEY,
    CELL_SEEK_POS,
    CELL_DRAIN
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

@@ hw/rtl/oal_req_if.sv @@
interface oal_req_if;
  import oal_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CMD_BITS-1:0]          command;
  logic [POS_BITS-1:0]          position;
  logic                         at_end;
  logic [KEY_PORT_BITS-1:0]     item_key;
  logic [PAYLOAD_PORT_BITS-1:0] item_payload;

  modport source (
    output valid, command, position, at_end, item_key, item_payload,
    input  ready
  );

  modport sink (
    input  valid, command, position, at_end, item_key, item_payload,
    output ready
  );
endinterface

@@ hw/rtl/oal_rsp_if.sv @@
interface oal_rsp_if;
  import oal_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [STATUS_BITS-1:0]       status;
  logic [POS_BITS-1:0]          found_position;
  logic [KEY_PORT_BITS-1:0]     read_key;
  logic [PAYLOAD_PORT_BITS-1:0] read_payload;
  logic [TOTAL_BITS-1:0]        entry_total;

  modport source (
    output valid, status, found_position, read_key, read_payload, entry_total,
    input  ready
  );

  modport sink (
    input  valid, status, found_position, read_key, read_payload, entry_total,
    output ready
  );
endinterface

@@ hw/rtl/oal_cell.sv @@
module oal_cell #(
  parameter int KEY_BITS  = 64,
  parameter int PAY_BITS  = 32,
  parameter int IW        = 5,
  parameter int CW        = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  oal_pkg::cell_op_t    op,
  input  logic [IW-1:0]        cell_index,
  input  logic [CW-1:0]        count,
  input  logic [IW-1:0]        target,
  input  logic [KEY_BITS-1:0]  new_key,
  input  logic [PAY_BITS-1:0]  new_payload,
  input  logic [KEY_BITS-1:0]  lower_key,
  input  logic [PAY_BITS-1:0]  lower_payload,
  input  logic [KEY_BITS-1:0]  upper_key,
  input  logic [PAY_BITS-1:0]  upper_payload,
  input  logic                 upper_hit,
  input  logic [IW-1:0]        upper_index,
  input  logic [KEY_BITS-1:0]  upper_bus_key,
  input  logic [PAY_BITS-1:0]  upper_bus_payload,
  output logic [KEY_BITS-1:0]  key,
  output logic [PAY_BITS-1:0]  payload,
  output logic                 bus_hit,
  output logic [IW-1:0]        bus_index,
  output logic [KEY_BITS-1:0]  bus_key,
  output logic [PAY_BITS-1:0]  bus_payload
);
  import oal_pkg::*;

  logic occupied;

  assign occupied = CW'(cell_index) < count;

  // Stored entry: shifts with its neighbors on insert and delete; rewritten in place on update.
  always_ff @(posedge clk) begin
    case (op)
      CELL_INSERT: begin
        if (cell_index > target) begin
          key     <= lower_key;
          payload <= lower_payload;
        end else if (cell_index == target) begin
          key     <= new_key;
          payload <= new_payload;
        end
      end
      CELL_DELETE: begin
        if (cell_index >= target) begin
          key     <= upper_key;
          payload <= upper_payload;
        end
      end
      CELL_UPDATE: begin
        if (cell_index == target) begin
          key     <= new_key;
          payload <= new_payload;
        end
      end
      default: begin
      end
    endcase
  end

  // Result bus: loaded in parallel, then drained toward cell 0. A cell that
  // holds a hit keeps it, so the lowest hit is the one that reaches cell 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_hit <= 1'b0;
    end else begin
      case (op)
        CELL_SEEK_KEY: bus_hit <= occupied && (key == new_key);
        CELL_SEEK_POS: bus_hit <= occupied && (cell_index == target);
        CELL_DRAIN: begin
          if (!bus_hit) begin
            bus_hit <= upper_hit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op) inside
      CELL_SEEK_KEY, CELL_SEEK_POS: begin
        bus_index   <= cell_index;
        bus_key     <= key;
        bus_payload <= payload;
      end
      CELL_DRAIN: begin
        if (!bus_hit) begin
          bus_index   <= upper_index;
          bus_key     <= upper_bus_key;
          bus_payload <= upper_bus_payload;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/ordered_array_list_engine.sv @@
// Ordered array list engine.
// Holds up to DEPTH entries, each a key and a payload, packed from position 0.
// Requests arrive on the request channel (valid/ready) carrying a command,
// position, append flag, key and payload; every request produces exactly one
// result on the result channel with a status, the found position, read data
// and the entry total after the command.
// Insert, delete, update, clear and any request refused for a bad position
// or a full list finish at once: the result is registered at the edge that
// accepts the request. Read and find load every cell's result bus in the
// accept cycle and then drain it toward cell 0, one cell per cycle; the
// result is registered once cell 0's bus holds a hit or every cell has been
// seen, and the output register is free.
// One request is in flight at a time. A new request is taken while the
// block is idle and the result register is empty or being emptied, so an
// immediate command can be accepted in the same cycle as the previous
// result leaves.
// If the receiver stalls, the result stays in the output register and the
// request channel stays closed until it is taken.
// Reset empties the list and the result register; stored entries are not
// cleared and are never reported until written.
module ordered_array_list_engine #(
  parameter int DEPTH        = 32,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  oal_req_if.sink   request,
  oal_rsp_if.source result
);
  import oal_pkg::*;

  // Payloads wider than the channel carry nothing extra.
  localparam int PW = (PAYLOAD_BITS < PAYLOAD_PORT_BITS) ? PAYLOAD_BITS : PAYLOAD_PORT_BITS;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = CW + POS_BITS;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_INDEX = IW'(DEPTH - 1);

  // Control registers.
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] scan_count, scan_count_next;
  logic          scan_find, scan_find_next;
  logic          out_valid, out_valid_next;

  // Result register.
  status_t                      out_status, out_status_next;
  logic [POS_BITS-1:0]          out_found, out_found_next;
  logic [KEY_PORT_BITS-1:0]     out_key, out_key_next;
  logic [PAYLOAD_PORT_BITS-1:0] out_payload, out_payload_next;
  logic [TOTAL_BITS-1:0]        out_total, out_total_next;

  // Cell chain hookup.
  cell_op_t          cell_op;
  logic [IW-1:0]     target;
  logic [KEY_BITS-1:0] ent_key [DEPTH];
  logic [PW-1:0]       ent_payload [DEPTH];
  logic                bus_hit [DEPTH];
  logic [IW-1:0]       bus_index [DEPTH];
  logic [KEY_BITS-1:0] bus_key [DEPTH];
  logic [PW-1:0]       bus_payload [DEPTH];

  logic [KEY_BITS-1:0] new_key;
  logic [PW-1:0]       new_payload;
  logic                accept;
  logic                slot_free;
  logic                scan_done;
  logic [WW-1:0]       pos_w, count_w, at_w;
  logic [WW-1:0]       index_w;
  logic [CW+TOTAL_BITS-1:0] total_w;

  assign new_key     = request.item_key[KEY_BITS-1:0];
  assign new_payload = request.item_payload[PW-1:0];

  assign slot_free     = !out_valid || result.ready;
  assign request.ready = (state == ST_IDLE) && slot_free;
  assign accept        = request.valid && request.ready;

  assign pos_w   = WW'(request.position);
  assign count_w = WW'(count);
  assign at_w    = request.at_end ? count_w : pos_w;
  assign index_w = WW'(bus_index[0]);

  // Cell 0's bus has seen cells 0..scan_count; scan_count counts the drain steps.
  assign scan_done = bus_hit[0] || (scan_count == LAST_INDEX);

  always_comb begin
    state_next       = state;
    count_next       = count;
    scan_count_next  = scan_count;
    scan_find_next   = scan_find;
    out_valid_next   = out_valid && !result.ready;
    out_status_next  = out_status;
    out_found_next   = out_found;
    out_key_next     = out_key;
    out_payload_next = out_payload;
    out_total_next   = out_total;
    cell_op          = CELL_HOLD;
    target           = pos_w[IW-1:0];
    total_w          = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          out_status_next  = STATUS_OK;
          out_found_next   = '0;
          out_key_next     = '0;
          out_payload_next = '0;
          out_valid_next   = 1'b1;
          unique case (cmd_t'(request.command))
            CMD_INSERT: begin
              if (count == FULL_COUNT) begin
                out_status_next = STATUS_FULL;
              end else if (at_w > count_w) begin
                out_status_next = STATUS_BAD_POSITION;
              end else begin
                cell_op    = CELL_INSERT;
                target     = at_w[IW-1:0];
                count_next = count + 1'b1;
              end
            end
            CMD_DELETE: begin
              if (pos_w >= count_w) begin
                out_status_next = STATUS_BAD_POSITION;
              end else begin
                cell_op    = CELL_DELETE;
                count_next = count - 1'b1;
              end
            end
            CMD_UPDATE: begin
              if (pos_w >= count_w) begin
                out_status_next = STATUS_BAD_POSITION;
              end else begin
                cell_op = CELL_UPDATE;
              end
            end
            CMD_READ: begin
              if (pos_w >= count_w) begin
                out_status_next = STATUS_BAD_POSITION;
              end else begin
                cell_op         = CELL_SEEK_POS;
                state_next      = ST_SCAN;
                scan_find_next  = 1'b0;
                scan_count_next = '0;
                out_valid_next  = 1'b0;
              end
            end
            CMD_FIND: begin
              cell_op         = CELL_SEEK_KEY;
              state_next      = ST_SCAN;
              scan_find_next  = 1'b1;
              scan_count_next = '0;
              out_valid_next  = 1'b0;
            end
            CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
          total_w        = (CW + TOTAL_BITS)'(count_next);
          out_total_next = total_w[TOTAL_BITS-1:0];
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          cell_op         = CELL_DRAIN;
          scan_count_next = scan_count + 1'b1;
        end else if (slot_free) begin
          state_next       = ST_IDLE;
          out_valid_next   = 1'b1;
          out_status_next  = bus_hit[0] ? STATUS_OK : STATUS_NO_KEY;
          out_found_next   = '0;
          out_key_next     = '0;
          out_payload_next = '0;
          if (scan_find) begin
            if (bus_hit[0]) begin
              out_found_next = index_w[POS_BITS-1:0];
            end
          end else begin
            out_key_next[KEY_BITS-1:0] = bus_key[0];
            out_payload_next[PW-1:0]   = bus_payload[0];
          end
          total_w        = (CW + TOTAL_BITS)'(count);
          out_total_next = total_w[TOTAL_BITS-1:0];
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      scan_count <= '0;
      scan_find  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      scan_count <= scan_count_next;
      scan_find  <= scan_find_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status  <= out_status_next;
    out_found   <= out_found_next;
    out_key     <= out_key_next;
    out_payload <= out_payload_next;
    out_total   <= out_total_next;
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.found_position = out_found;
  assign result.read_key       = out_key;
  assign result.read_payload   = out_payload;
  assign result.entry_total    = out_total;

  // The chain: each cell sees the entry below it (for insert) and the entry
  // and result bus above it (for delete and the drain). The ends see zeros.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] lo_key;
    logic [PW-1:0]       lo_payload;
    logic [KEY_BITS-1:0] up_key;
    logic [PW-1:0]       up_payload;
    logic                up_hit;
    logic [IW-1:0]       up_index;
    logic [KEY_BITS-1:0] up_bus_key;
    logic [PW-1:0]       up_bus_payload;

    if (i == 0) begin : g_bottom
      assign lo_key     = '0;
      assign lo_payload = '0;
    end else begin : g_lower
      assign lo_key     = ent_key[i-1];
      assign lo_payload = ent_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign up_key         = '0;
      assign up_payload     = '0;
      assign up_hit         = 1'b0;
      assign up_index       = '0;
      assign up_bus_key     = '0;
      assign up_bus_payload = '0;
    end else begin : g_upper
      assign up_key         = ent_key[i+1];
      assign up_payload     = ent_payload[i+1];
      assign up_hit         = bus_hit[i+1];
      assign up_index       = bus_index[i+1];
      assign up_bus_key     = bus_key[i+1];
      assign up_bus_payload = bus_payload[i+1];
    end

    oal_cell #(
      .KEY_BITS (KEY_BITS),
      .PAY_BITS (PW),
      .IW       (IW),
      .CW       (CW)
    ) u_cell (
      .clk               (clk),
      .rst               (rst),
      .op                (cell_op),
      .cell_index        (IW'(i)),
      .count             (count),
      .target            (target),
      .new_key           (new_key),
      .new_payload       (new_payload),
      .lower_key         (lo_key),
      .lower_payload     (lo_payload),
      .upper_key         (up_key),
      .upper_payload     (up_payload),
      .upper_hit         (up_hit),
      .upper_index       (up_index),
      .upper_bus_key     (up_bus_key),
      .upper_bus_payload (up_bus_payload),
      .key               (ent_key[i]),
      .payload           (ent_payload[i]),
      .bus_hit           (bus_hit[i]),
      .bus_index         (bus_index[i]),
      .bus_key           (bus_key[i]),
      .bus_payload       (bus_payload[i])
    );
  end

endmodule
